FILE: sv/tapmc_pkg.sv
// shared types and constants of the two-axis point move controller
`timescale 1ns / 1ps

package tapmc_pkg;

   // fixed field widths
   localparam int FIELD_W      = 24;
   localparam int SPEED_W      = 7;
   localparam int TOL_W        = 23;
   localparam int MPC_W        = 16;
   localparam int DRIVE_W      = 8;
   localparam int PROD_W       = FIELD_W + MPC_W;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 23;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MM_PER_COUNT = 2'd2;

   // register reset values
   localparam logic [SPEED_W-1:0] SPEED_RESET     = 7'd50;
   localparam logic [TOL_W-1:0]   TOLERANCE_RESET = 23'd256;
   localparam logic [MPC_W-1:0]   MPC_RESET       = 16'd256;

   // transaction kinds
   localparam logic KIND_START  = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   // drive clamp magnitude
   localparam logic [DRIVE_W-1:0] DRIVE_LIMIT = 8'd100;

   typedef struct packed {
      logic                      kind;
      logic signed [FIELD_W-1:0] target_x;
      logic signed [FIELD_W-1:0] target_y;
      logic signed [FIELD_W-1:0] count_x;
      logic signed [FIELD_W-1:0] count_y;
   } req_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive_x;
      logic signed [DRIVE_W-1:0] drive_y;
      logic                      done_res;
   } rsp_type;

endpackage

FILE: sv/two_axis_point_move_controller.sv
// top level of the two-axis point move controller
`timescale 1ns / 1ps

// Two-axis point-to-point move controller. A start transaction (kind 0) latches
// a new X/Y goal, converts the encoder counts to mm Q8 (count * mm_per_count),
// forms the per-axis deltas and the distance isqrt(dx^2 + dy^2), and gives each
// axis whose |delta| exceeds tolerance_mm the drive speed*|delta|/distance,
// truncated, signed like the delta and clamped to +/-100; other axes keep their
// drive. A sample transaction (kind 1) zeroes the drive of each axis strictly
// within tolerance. Every transaction returns one result with both drives and
// done (both axes strictly within tolerance). Goals and positions saturate to
// the signed POSITION_BITS range. The datapath is bit serial: the count scaling
// walks mm_per_count one bit a cycle, the squares walk the scaled deltas one
// bit a cycle, the root gives one result bit a cycle and the division one
// quotient bit a cycle. One transaction is in work at a time: req_ready stays
// low from the accept until the result goes to the output register. The result
// sits in an output register, so the next transaction is taken while a result
// still waits for rsp_ready. Configuration writes take effect at once and are
// meant for idle periods.
module two_axis_point_move_controller #(
   parameter int POSITION_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  tapmc_pkg::req_type                  req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tapmc_pkg::rsp_type                  rsp_payload,
   input  logic                                csr_write_en,
   input  logic [tapmc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tapmc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tapmc_pkg::*;

   localparam int P      = POSITION_BITS;
   localparam int SQ_W   = 2 * P;            // one square
   localparam int SUM_W  = 2 * P + 1;        // sum of two squares
   localparam int DIV_W  = P + SPEED_W;      // speed * scaled delta
   localparam int CNT_W  = $clog2(P + 1);
   localparam int CMP_W  = (P > TOL_W) ? P : TOL_W;

   localparam logic signed [PROD_W-1:0] POS_HI =
      PROD_W'((longint'(1) <<< (P - 1)) - longint'(1));
   localparam logic signed [PROD_W-1:0] POS_LO = -POS_HI - PROD_W'(1);

   // cap for the scaled deltas: 2^31
   localparam logic [32:0] DELTA_CAP = 33'h0_8000_0000;

   // sequencer codes
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_MULT   = 4'd1;
   localparam logic [3:0] S_DELTA  = 4'd2;
   localparam logic [3:0] S_SQUARE = 4'd3;
   localparam logic [3:0] S_SUMSQ  = 4'd4;
   localparam logic [3:0] S_ROOT   = 4'd5;
   localparam logic [3:0] S_PREP   = 4'd6;
   localparam logic [3:0] S_DIVIDE = 4'd7;
   localparam logic [3:0] S_RESULT = 4'd8;

   // saturate a scaled position or target to the position range
   function automatic logic signed [P-1:0] sat_pos(input logic signed [PROD_W-1:0] v);
      logic signed [P-1:0] r;
      if (v > POS_HI) begin
         r = POS_HI[P-1:0];
      end else if (v < POS_LO) begin
         r = POS_LO[P-1:0];
      end else begin
         r = v[P-1:0];
      end
      return r;
   endfunction

   // clamp the quotient, apply the delta's sign; zero when the distance is zero
   function automatic logic [DRIVE_W-1:0] drive_of(input logic [SPEED_W-1:0] q,
                                                   input logic neg, input logic dz);
      logic [DRIVE_W-1:0] qc;
      logic [DRIVE_W-1:0] r;
      qc = DRIVE_W'(q);
      if (qc > DRIVE_LIMIT) begin
         qc = DRIVE_LIMIT;
      end
      if (dz) begin
         r = '0;
      end else if (neg) begin
         r = -qc;
      end else begin
         r = qc;
      end
      return r;
   endfunction

   // control state
   logic [3:0]             state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // configuration
   logic [SPEED_W-1:0]     speed_ff, speed_in;
   logic [TOL_W-1:0]       tol_ff, tol_in;
   logic [MPC_W-1:0]       mpc_ff, mpc_in;

   // architectural state
   logic signed [P-1:0]    goal_x_ff, goal_x_in;
   logic signed [P-1:0]    goal_y_ff, goal_y_in;
   logic [DRIVE_W-1:0]     power_x_ff, power_x_in;
   logic [DRIVE_W-1:0]     power_y_ff, power_y_in;

   // datapath
   logic                   kind_ff, kind_in;
   rsp_type                rsp_ff, rsp_in;
   logic [MPC_W-1:0]       msr_ff, msr_in;
   logic [PROD_W-1:0]      mcx_ff, mcx_in, mcy_ff, mcy_in;
   logic [PROD_W-1:0]      accx_ff, accx_in, accy_ff, accy_in;
   logic                   neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic                   gt_x_ff, gt_x_in, gt_y_ff, gt_y_in;
   logic                   lt_x_ff, lt_x_in, lt_y_ff, lt_y_in;
   logic [P-1:0]           sx_ff, sx_in, sy_ff, sy_in;
   logic [P-1:0]           qsx_ff, qsx_in, qsy_ff, qsy_in;
   logic [SQ_W-1:0]        qmx_ff, qmx_in, qmy_ff, qmy_in;
   logic [SQ_W-1:0]        qax_ff, qax_in, qay_ff, qay_in;
   logic [SUM_W-1:0]       rn_ff, rn_in, rres_ff, rres_in, rbit_ff, rbit_in;
   logic [DIV_W-1:0]       dv_ff, dv_in, remx_ff, remx_in, remy_ff, remy_in;
   logic                   dz_ff, dz_in;
   logic [SPEED_W-1:0]     qx_ff, qx_in, qy_ff, qy_in;

   // combinational helpers
   logic                   accept;
   logic                   out_free;
   logic                   rsp_load;
   logic signed [P-1:0]    px, py;
   logic [P:0]             dx, dy, ndx, ndy;
   logic [P-1:0]           ax, ay;
   logic [32:0]            ax_w, ay_w;
   logic                   big;
   logic [SUM_W-1:0]       rtrial;
   logic [P:0]             root_len;
   logic [DRIVE_W-1:0]     drv_x, drv_y;

   assign req_ready   = (state_ff == S_IDLE);
   assign accept      = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_load    = (state_ff == S_RESULT) && out_free;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // position, delta and magnitude from the serial products
   always_comb begin
      px       = sat_pos(signed'(accx_ff));
      py       = sat_pos(signed'(accy_ff));
      dx       = {goal_x_ff[P-1], goal_x_ff} - {px[P-1], px};
      dy       = {goal_y_ff[P-1], goal_y_ff} - {py[P-1], py};
      ndx      = -dx;
      ndy      = -dy;
      ax       = dx[P] ? ndx[P-1:0] : dx[P-1:0];
      ay       = dy[P] ? ndy[P-1:0] : dy[P-1:0];
      ax_w     = 33'(ax);
      ay_w     = 33'(ay);
      big      = (ax_w > DELTA_CAP) || (ay_w > DELTA_CAP);
      rtrial   = rres_ff + rbit_ff;
      root_len = rres_ff[P:0];
      drv_x    = drive_of(qx_ff, neg_x_ff, dz_ff);
      drv_y    = drive_of(qy_ff, neg_y_ff, dz_ff);
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      speed_in     = speed_ff;
      tol_in       = tol_ff;
      mpc_in       = mpc_ff;
      goal_x_in    = goal_x_ff;
      goal_y_in    = goal_y_ff;
      power_x_in   = power_x_ff;
      power_y_in   = power_y_ff;
      kind_in      = kind_ff;
      rsp_in       = rsp_ff;
      msr_in       = msr_ff;
      mcx_in       = mcx_ff;
      mcy_in       = mcy_ff;
      accx_in      = accx_ff;
      accy_in      = accy_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      gt_x_in      = gt_x_ff;
      gt_y_in      = gt_y_ff;
      lt_x_in      = lt_x_ff;
      lt_y_in      = lt_y_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      qsx_in       = qsx_ff;
      qsy_in       = qsy_ff;
      qmx_in       = qmx_ff;
      qmy_in       = qmy_ff;
      qax_in       = qax_ff;
      qay_in       = qay_ff;
      rn_in        = rn_ff;
      rres_in      = rres_ff;
      rbit_in      = rbit_ff;
      dv_in        = dv_ff;
      remx_in      = remx_ff;
      remy_in      = remy_ff;
      dz_in        = dz_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;

      // register writes
      if (csr_write_en) begin
         case (csr_index)
            CSR_SPEED:        speed_in = csr_wdata[SPEED_W-1:0];
            CSR_TOLERANCE:    tol_in   = csr_wdata[TOL_W-1:0];
            CSR_MM_PER_COUNT: mpc_in   = csr_wdata[MPC_W-1:0];
            default:          ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in = req_payload.kind;
               msr_in  = mpc_ff;
               mcx_in  = PROD_W'($signed(req_payload.count_x));
               mcy_in  = PROD_W'($signed(req_payload.count_y));
               accx_in = '0;
               accy_in = '0;
               cnt_in  = CNT_W'(MPC_W - 1);
               if (req_payload.kind == KIND_START) begin
                  goal_x_in = sat_pos(PROD_W'($signed(req_payload.target_x)));
                  goal_y_in = sat_pos(PROD_W'($signed(req_payload.target_y)));
               end
               state_in = S_MULT;
            end
         end
         // count * mm_per_count, one multiplier bit a cycle
         S_MULT: begin
            if (msr_ff[0]) begin
               accx_in = accx_ff + mcx_ff;
               accy_in = accy_ff + mcy_ff;
            end
            mcx_in = mcx_ff << 1;
            mcy_in = mcy_ff << 1;
            msr_in = msr_ff >> 1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = S_DELTA;
            end
         end
         S_DELTA: begin
            neg_x_in = dx[P];
            neg_y_in = dy[P];
            gt_x_in  = CMP_W'(ax) > CMP_W'(tol_ff);
            gt_y_in  = CMP_W'(ay) > CMP_W'(tol_ff);
            lt_x_in  = CMP_W'(ax) < CMP_W'(tol_ff);
            lt_y_in  = CMP_W'(ay) < CMP_W'(tol_ff);
            sx_in    = big ? (ax >> 1) : ax;
            sy_in    = big ? (ay >> 1) : ay;
            qsx_in   = sx_in;
            qsy_in   = sy_in;
            qmx_in   = SQ_W'(sx_in);
            qmy_in   = SQ_W'(sy_in);
            qax_in   = '0;
            qay_in   = '0;
            cnt_in   = CNT_W'(P - 1);
            state_in = (kind_ff == KIND_SAMPLE) ? S_RESULT : S_SQUARE;
         end
         // squares, one bit of the scaled delta a cycle
         S_SQUARE: begin
            if (qsx_ff[0]) begin
               qax_in = qax_ff + qmx_ff;
            end
            if (qsy_ff[0]) begin
               qay_in = qay_ff + qmy_ff;
            end
            qmx_in = qmx_ff << 1;
            qmy_in = qmy_ff << 1;
            qsx_in = qsx_ff >> 1;
            qsy_in = qsy_ff >> 1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = S_SUMSQ;
            end
         end
         S_SUMSQ: begin
            rn_in    = SUM_W'(qax_ff) + SUM_W'(qay_ff);
            rres_in  = '0;
            rbit_in  = {1'b1, {(SUM_W - 1){1'b0}}};
            cnt_in   = CNT_W'(P);
            state_in = S_ROOT;
         end
         // integer square root, one result bit a cycle
         S_ROOT: begin
            if (rn_ff >= rtrial) begin
               rn_in   = rn_ff - rtrial;
               rres_in = (rres_ff >> 1) + rbit_ff;
            end else begin
               rres_in = rres_ff >> 1;
            end
            rbit_in = rbit_ff >> 2;
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            dv_in    = {root_len, {(SPEED_W - 1){1'b0}}};
            remx_in  = DIV_W'(speed_ff) * DIV_W'(sx_ff);
            remy_in  = DIV_W'(speed_ff) * DIV_W'(sy_ff);
            dz_in    = (root_len == '0);
            qx_in    = '0;
            qy_in    = '0;
            cnt_in   = CNT_W'(SPEED_W - 1);
            state_in = S_DIVIDE;
         end
         // restoring division, one quotient bit a cycle, both axes share the divisor
         S_DIVIDE: begin
            if (remx_ff >= dv_ff) begin
               remx_in = remx_ff - dv_ff;
               qx_in   = {qx_ff[SPEED_W-2:0], 1'b1};
            end else begin
               qx_in   = {qx_ff[SPEED_W-2:0], 1'b0};
            end
            if (remy_ff >= dv_ff) begin
               remy_in = remy_ff - dv_ff;
               qy_in   = {qy_ff[SPEED_W-2:0], 1'b1};
            end else begin
               qy_in   = {qy_ff[SPEED_W-2:0], 1'b0};
            end
            dv_in  = dv_ff >> 1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = S_RESULT;
            end
         end
         // update the drives and hand the result to the output register
         S_RESULT: begin
            if (out_free) begin
               if (kind_ff == KIND_START) begin
                  if (gt_x_ff) begin
                     power_x_in = drv_x;
                  end
                  if (gt_y_ff) begin
                     power_y_in = drv_y;
                  end
               end else begin
                  if (lt_x_ff) begin
                     power_x_in = '0;
                  end
                  if (lt_y_ff) begin
                     power_y_in = '0;
                  end
               end
               rsp_in.drive_x  = power_x_in;
               rsp_in.drive_y  = power_y_in;
               rsp_in.done_res = lt_x_ff && lt_y_ff;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         speed_ff     <= SPEED_RESET;
         tol_ff       <= TOLERANCE_RESET;
         mpc_ff       <= MPC_RESET;
         goal_x_ff    <= '0;
         goal_y_ff    <= '0;
         power_x_ff   <= '0;
         power_y_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         speed_ff     <= speed_in;
         tol_ff       <= tol_in;
         mpc_ff       <= mpc_in;
         goal_x_ff    <= goal_x_in;
         goal_y_ff    <= goal_y_in;
         power_x_ff   <= power_x_in;
         power_y_ff   <= power_y_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      rsp_ff   <= rsp_in;
      msr_ff   <= msr_in;
      mcx_ff   <= mcx_in;
      mcy_ff   <= mcy_in;
      accx_ff  <= accx_in;
      accy_ff  <= accy_in;
      neg_x_ff <= neg_x_in;
      neg_y_ff <= neg_y_in;
      gt_x_ff  <= gt_x_in;
      gt_y_ff  <= gt_y_in;
      lt_x_ff  <= lt_x_in;
      lt_y_ff  <= lt_y_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      qsx_ff   <= qsx_in;
      qsy_ff   <= qsy_in;
      qmx_ff   <= qmx_in;
      qmy_ff   <= qmy_in;
      qax_ff   <= qax_in;
      qay_ff   <= qay_in;
      rn_ff    <= rn_in;
      rres_ff  <= rres_in;
      rbit_ff  <= rbit_in;
      dv_ff    <= dv_in;
      remx_ff  <= remx_in;
      remy_ff  <= remy_in;
      dz_ff    <= dz_in;
      qx_ff    <= qx_in;
      qy_ff    <= qy_in;
   end

   // one transaction in work at a time
   a_single_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("transaction taken while another is in work");

   // a delivered drive never leaves the clamp range
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_payload.drive_x) <= $signed(DRIVE_LIMIT)) &&
                    ($signed(rsp_payload.drive_x) >= -$signed(DRIVE_LIMIT)) &&
                    ($signed(rsp_payload.drive_y) <= $signed(DRIVE_LIMIT)) &&
                    ($signed(rsp_payload.drive_y) >= -$signed(DRIVE_LIMIT)))
      else $error("drive outside clamp range");

   // a sample that reports done has stopped both axes
   a_done_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (kind_ff == KIND_SAMPLE) && lt_x_ff && lt_y_ff) |=>
         (rsp_payload.drive_x == '0) && (rsp_payload.drive_y == '0) && rsp_payload.done_res)
      else $error("done sample left an axis driven");

endmodule
